@@ hdl/utf8_text_normalizer_assert.svh @@
// Assertion macros for the normalizer modules, used by utn_emit.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef UTF8_TEXT_NORMALIZER_ASSERT_SVH
`define UTF8_TEXT_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define UTN_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("utn assertion failed");

// Check that a condition never holds at a clock edge out of reset.
`define UTN_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("utn forbidden condition seen");

`else

`define UTN_ASSERT(lbl, prop)
`define UTN_NEVER(lbl, cond)

`endif

`endif

@@ hdl/utn_pkg.sv @@
package utn_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_LOWER_CASE   = 2'd0;
	localparam logic [1:0] CFG_STRIP_ACCENT = 2'd1;

	localparam int CP_W      = 21;
	localparam int MAX_BYTES = 6;

	// Codepoint constants
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_TAB         = 21'h000009;
	localparam logic [CP_W-1:0] CP_LF          = 21'h00000A;
	localparam logic [CP_W-1:0] CP_CR          = 21'h00000D;
	localparam logic [CP_W-1:0] CP_SPACE       = 21'h000020;
	localparam logic [CP_W-1:0] CP_NBSP        = 21'h0000A0;
	localparam logic [CP_W-1:0] CP_LINE_SEP    = 21'h002028;
	localparam logic [CP_W-1:0] CP_PARA_SEP    = 21'h002029;
	localparam logic [CP_W-1:0] CP_DEL         = 21'h00007F;
	localparam logic [CP_W-1:0] CP_C1_LAST     = 21'h00009F;
	localparam logic [CP_W-1:0] CP_UPPER_A     = 21'h000041;
	localparam logic [CP_W-1:0] CP_UPPER_Z     = 21'h00005A;

	localparam logic [7:0] BYTE_SPACE = 8'h20;

	typedef struct packed {
		logic lower_case;
		logic strip_accent;
	} cfg_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} utf8_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] b;
		logic [2:0]                cnt;
	} emit_t;

	function automatic logic is_dropped(input logic [CP_W-1:0] cp);
		logic r;
		r = 1'b0;
		if (cp == CP_REPLACEMENT) r = 1'b1;
		else if (cp == CP_TAB || cp == CP_LF || cp == CP_CR) r = 1'b0;
		else if (cp < CP_SPACE) r = 1'b1;
		else r = (cp >= CP_DEL) && (cp <= CP_C1_LAST);
		return r;
	endfunction

	function automatic logic is_space(input logic [CP_W-1:0] cp);
		return cp == CP_SPACE || cp == CP_TAB || cp == CP_LF || cp == CP_CR ||
			cp == CP_NBSP || cp == CP_LINE_SEP || cp == CP_PARA_SEP;
	endfunction

	function automatic logic is_cjk(input logic [CP_W-1:0] cp);
		return (cp >= 21'h004E00 && cp <= 21'h009FFF) ||
			(cp >= 21'h003400 && cp <= 21'h004DBF) ||
			(cp >= 21'h020000 && cp <= 21'h02A6DF) ||
			(cp >= 21'h00F900 && cp <= 21'h00FAFF);
	endfunction

	// Base letter of a Latin-1 accented letter, zero when there is none
	function automatic logic [7:0] accent_base(input logic [CP_W-1:0] cp);
		logic [7:0] c;
		logic [7:0] r;
		c = cp[7:0];
		r = 8'h00;
		if (cp >= 21'h0000C0 && cp <= 21'h0000FF) begin
			if (c >= 8'hE0) c = c - 8'h20;
			if (cp == 21'h0000FF) r = "y";
			else if (c <= 8'hC5) r = "a";
			else if (c == 8'hC7) r = "c";
			else if (c >= 8'hC8 && c <= 8'hCB) r = "e";
			else if (c >= 8'hCC && c <= 8'hCF) r = "i";
			else if (c == 8'hD1) r = "n";
			else if (c >= 8'hD2 && c <= 8'hD6) r = "o";
			else if (c >= 8'hD9 && c <= 8'hDC) r = "u";
			else if (c == 8'hDD) r = "y";
		end
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h000080) begin
			r.b[0] = cp[7:0];
			r.len  = 3'd1;
		end else if (cp < 21'h000800) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.len  = 3'd2;
		end else if (cp < 21'h010000) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.len  = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.len  = 3'd4;
		end
		return r;
	endfunction

endpackage

@@ hdl/utn_decode.sv @@
module utn_decode
	import utn_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            end_of_text,
	output logic            cp_valid_s1,
	input  logic            cp_ready,
	output logic [CP_W-1:0] cp_s1
);

	logic [CP_W-1:0] part_q, part_d;
	logic [1:0]      rem_q, rem_d;
	logic            done;
	logic            accept;

	// Take a new beat when stage 1 is empty or is moving on
	assign in_ready = !cp_valid_s1 || cp_ready;
	assign accept   = in_valid && in_ready;

	// Fold the byte into the open sequence or start a new one
	always_comb begin
		part_d = part_q;
		rem_d  = rem_q;
		priority if (rem_q != 2'd0) begin
			part_d = {part_q[CP_W-7:0], in_byte[5:0]};
			rem_d  = rem_q - 2'd1;
		end else if (in_byte[7:5] == 3'b110) begin
			part_d = {16'd0, in_byte[4:0]};
			rem_d  = 2'd1;
		end else if (in_byte[7:4] == 4'b1110) begin
			part_d = {17'd0, in_byte[3:0]};
			rem_d  = 2'd2;
		end else if (in_byte[7:3] == 5'b11110) begin
			part_d = {18'd0, in_byte[2:0]};
			rem_d  = 2'd3;
		end else begin
			part_d = {13'd0, in_byte};
			rem_d  = 2'd0;
		end
		done = (rem_d == 2'd0) || end_of_text;
	end

	// Hold the accumulator; close it when a codepoint completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			rem_q  <= '0;
		end else if (accept) begin
			if (done) begin
				part_q <= '0;
				rem_q  <= '0;
			end else begin
				part_q <= part_d;
				rem_q  <= rem_d;
			end
		end
	end

	// Stage 1: completed codepoint
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid_s1 <= 1'b0;
		end else if (accept) begin
			cp_valid_s1 <= done;
		end else if (cp_ready) begin
			cp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cp_s1 <= part_d;
		end
	end

endmodule

@@ hdl/utn_emit.sv @@
`include "utf8_text_normalizer_assert.svh"

module utn_emit
	import utn_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            cp_valid,
	output logic            cp_ready,
	input  logic [CP_W-1:0] cp,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	emit_t      res;
	utf8_t      enc;
	logic [7:0] base;

	logic [MAX_BYTES-1:0][7:0] buf_q;
	logic [2:0]                cnt_q;
	logic [2:0]                idx_q;
	logic                      busy_q;
	logic                      last_take;
	logic                      load;

	// Classify the codepoint and build its output bytes
	always_comb begin
		enc  = utf8_encode(cp);
		base = accent_base(cp);
		res  = '0;
		priority if (is_dropped(cp)) begin
			res.cnt = 3'd0;
		end else if (is_space(cp)) begin
			res.b[0] = BYTE_SPACE;
			res.cnt  = 3'd1;
		end else if (cfg.strip_accent && base != 8'h00) begin
			res.b[0] = base;
			res.cnt  = 3'd1;
		end else if (cfg.lower_case && cp >= CP_UPPER_A && cp <= CP_UPPER_Z) begin
			res.b[0] = cp[7:0] + 8'h20;
			res.cnt  = 3'd1;
		end else if (is_cjk(cp)) begin
			res.b[0] = BYTE_SPACE;
			res.b[1] = enc.b[0];
			res.b[2] = enc.b[1];
			res.b[3] = enc.b[2];
			res.b[4] = enc.b[3];
			res.cnt  = enc.len + 3'd2;
			res.b[enc.len + 3'd1] = BYTE_SPACE;
		end else begin
			res.b[3:0] = enc.b;
			res.cnt    = enc.len;
		end
	end

	// Drain the result register one beat at a time
	assign out_valid   = busy_q;
	assign out_byte    = buf_q[idx_q];
	assign last_of_run = (idx_q == cnt_q - 3'd1);
	assign last_take   = busy_q && out_ready && last_of_run;
	assign cp_ready    = !busy_q || last_take;
	assign load        = cp_valid && cp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= (res.cnt != 3'd0);
			idx_q  <= '0;
			cnt_q  <= res.cnt;
		end else if (busy_q && out_ready) begin
			if (last_of_run) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.b;
		end
	end

	`UTN_ASSERT(a_busy_has_bytes, busy_q |-> (cnt_q != 3'd0))
	`UTN_ASSERT(a_idx_in_range, busy_q |-> (idx_q < cnt_q))
	`UTN_ASSERT(a_load_starts_run, (load && res.cnt != 3'd0) |=> (busy_q && idx_q == 3'd0))
	`UTN_NEVER(a_no_overrun, cnt_q > 3'd6)

endmodule

@@ hdl/utf8_text_normalizer.sv @@
// UTF-8 text normalizer.
// Input stream s_axis: one text byte per beat in tdata, tlast marks the
// final byte of the text. Output stream m_axis: one normalized byte per beat
// in tdata, tlast marks the final byte produced by one input byte. An input
// byte yields zero to six output bytes.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 lower case enable,
// 1 accent strip enable) and cfg_data; write only while the block is idle.
// Path: a completing byte is decoded into the stage register cp_s1, then
// classified into the result register, from which its first output byte
// shows on m_axis; a stall can hold it in either register.
// Throughput: one input byte per cycle while each yields at most one output
// byte and the receiver does not stall; an input byte with N output bytes
// holds the result register until all N leave the single output byte port.
// Reset clears the decoder accumulator and both pipeline stages and sets
// both enables to 1. When the receiver stalls, the result register holds its
// beat and s_axis_tready falls once the decode stage is also full.
module utf8_text_normalizer
	import utn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,  // end_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,  // last_of_run
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);

	cfg_t            cfg_q;
	logic            cp_valid_s1;
	logic            cp_ready;
	logic [CP_W-1:0] cp_s1;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_case   <= 1'b1;
			cfg_q.strip_accent <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LOWER_CASE) cfg_q.lower_case <= cfg_data;
			if (cfg_index == CFG_STRIP_ACCENT) cfg_q.strip_accent <= cfg_data;
		end
	end

	utn_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.cp_valid_s1 (cp_valid_s1),
		.cp_ready    (cp_ready),
		.cp_s1       (cp_s1)
	);

	utn_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cp_valid    (cp_valid_s1),
		.cp_ready    (cp_ready),
		.cp          (cp_s1),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.last_of_run (m_axis_tlast)
	);

endmodule

@@ sim/testbench.sv @@
module testbench;
	import utn_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 160;
	localparam int REPORT_MAX    = 10;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} text_beat_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
	logic       s_axis_tlast  = 1'b0;   // end_of_text
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;           // last_of_run
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index     = CFG_LOWER_CASE;
	logic       cfg_data      = 1'b0;

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int sent_eot = 0;
	int settings = 1;

	// Plain UTF-8 encoding, up to 21-bit codepoints
	function automatic byte_q_t utf8_of(input logic [CP_W-1:0] cp);
		byte_q_t q;
		if (cp < 21'h80) begin
			q.insert(q.size(), cp[7:0]);
		end else if (cp < 21'h800) begin
			q.insert(q.size(), {3'b110, cp[10:6]});
			q.insert(q.size(), {2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			q.insert(q.size(), {4'b1110, cp[15:12]});
			q.insert(q.size(), {2'b10, cp[11:6]});
			q.insert(q.size(), {2'b10, cp[5:0]});
		end else begin
			q.insert(q.size(), {5'b11110, cp[20:18]});
			q.insert(q.size(), {2'b10, cp[17:12]});
			q.insert(q.size(), {2'b10, cp[11:6]});
			q.insert(q.size(), {2'b10, cp[5:0]});
		end
		return q;
	endfunction

	class normalized_text_tracker;
		cfg_t            regs;
		logic [CP_W-1:0] partial_cp;
		logic [1:0]      follow_left;
		text_beat_t      expected_bytes[$];
		int              errors;
		int              checked;
		int              noted;

		function new();
			regs.lower_case   = 1'b1;
			regs.strip_accent = 1'b1;
			partial_cp        = '0;
			follow_left       = '0;
			errors            = 0;
			checked           = 0;
			noted             = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic val);
			if (idx == CFG_LOWER_CASE) regs.lower_case = val;
			else if (idx == CFG_STRIP_ACCENT) regs.strip_accent = val;
		endfunction

		function bit gets_dropped(input logic [CP_W-1:0] cp);
			if (cp == 21'hFFFD) return 1'b1;
			if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D) return 1'b0;
			return cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F);
		endfunction

		function bit maps_to_space(input logic [CP_W-1:0] cp);
			return cp == 21'h20 || cp == 21'h09 || cp == 21'h0A || cp == 21'h0D ||
				cp == 21'hA0 || cp == 21'h2028 || cp == 21'h2029;
		endfunction

		function bit is_ideograph(input logic [CP_W-1:0] cp);
			return (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
				(cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'hF900 && cp <= 21'hFAFF);
		endfunction

		// Lowercase base letter of a Latin-1 accented letter, zero if none
		function logic [7:0] latin_base(input logic [CP_W-1:0] cp);
			logic [7:0] c;
			if (cp < 21'hC0 || cp > 21'hFF) return 8'h00;
			c = cp[7:0];
			if (c >= 8'hE0) c = c - 8'h20;
			if (cp == 21'hFF) return "y";
			if (c <= 8'hC5) return "a";
			if (c == 8'hC7) return "c";
			if (c >= 8'hC8 && c <= 8'hCB) return "e";
			if (c >= 8'hCC && c <= 8'hCF) return "i";
			if (c == 8'hD1) return "n";
			if (c >= 8'hD2 && c <= 8'hD6) return "o";
			if (c >= 8'hD9 && c <= 8'hDC) return "u";
			if (c == 8'hDD) return "y";
			return 8'h00;
		endfunction

		// Turn one finished codepoint into its expected output run
		function void normalize_codepoint(input logic [CP_W-1:0] cp);
			byte_q_t    run;
			byte_q_t    enc;
			logic [7:0] base;
			base = latin_base(cp);
			if (gets_dropped(cp)) begin
				return;
			end else if (maps_to_space(cp)) begin
				run.insert(run.size(), 8'h20);
			end else if (regs.strip_accent && base != 8'h00) begin
				run.insert(run.size(), base);
			end else if (regs.lower_case && cp >= 21'h41 && cp <= 21'h5A) begin
				run.insert(run.size(), cp[7:0] + 8'd32);
			end else begin
				enc = utf8_of(cp);
				if (is_ideograph(cp)) run.insert(run.size(), 8'h20);
				foreach (enc[i]) run.insert(run.size(), enc[i]);
				if (is_ideograph(cp)) run.insert(run.size(), 8'h20);
			end
			foreach (run[i])
				expected_bytes.insert(expected_bytes.size(),
					'{data: run[i], is_last: (i == run.size() - 1)});
		endfunction

		// Advance the lenient decoder by one accepted text byte
		function void note_text_byte(input logic [7:0] b, input logic eot);
			logic [CP_W-1:0] cp;
			noted++;
			if (follow_left != 2'd0) begin
				partial_cp  = {partial_cp[CP_W-7:0], b[5:0]};
				follow_left = follow_left - 2'd1;
			end else if (b[7:5] == 3'b110) begin
				partial_cp  = {16'd0, b[4:0]};
				follow_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				partial_cp  = {17'd0, b[3:0]};
				follow_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				partial_cp  = {18'd0, b[2:0]};
				follow_left = 2'd3;
			end else begin
				partial_cp  = {13'd0, b};
				follow_left = 2'd0;
			end
			if (follow_left != 2'd0 && !eot) return;
			cp          = partial_cp;
			partial_cp  = '0;
			follow_left = '0;
			normalize_codepoint(cp);
		endfunction

		// Compare one output beat with the oldest expected byte
		function void check_out_byte(input logic [7:0] data, input logic is_last);
			text_beat_t want;
			checked++;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("output beat %0d: got %02h last %0b, nothing expected",
						checked, data, is_last);
				return;
			end
			want = expected_bytes.pop_front();
			if (data !== want.data || is_last !== want.is_last) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("output beat %0d: expected %02h last %0b, got %02h last %0b",
						checked, want.data, want.is_last, data, is_last);
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function int failures();
			return errors + expected_bytes.size();
		endfunction
	endclass

	normalized_text_tracker text_check = new();

	utf8_text_normalizer uut (.*);

	always #5 clk = ~clk;

	// Stall the output side in random bursts, or for a long stretch on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				text_check.check_out_byte(m_axis_tdata, m_axis_tlast);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 16);
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// End the run when no beat moves for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one text byte, with an optional idle burst ahead of it
	task send_text_byte(input logic [7:0] b, input logic eot);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		text_check.note_text_byte(b, eot);
		if (eot) sent_eot++;
	endtask

	// Write one enable with valid held high; apply_settings drops it after the last write
	task write_reg(input logic [1:0] idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		text_check.set_reg(idx, val);
	endtask

	task apply_settings(input logic lower, input logic strip);
		write_reg(CFG_LOWER_CASE, lower);
		write_reg(CFG_STRIP_ACCENT, strip);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Wait for every expected byte, then let the pipeline empty
	task settle();
		s_axis_tvalid <= 1'b0;
		while (text_check.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Codepoints biased toward the ranges the normalizer treats specially
	function automatic logic [CP_W-1:0] pick_codepoint();
		case ($urandom_range(0, 9))
			0: return CP_W'($urandom_range(0, 'h7F));
			1: return CP_W'($urandom_range('h41, 'h5A));
			2: return CP_W'($urandom_range('h80, 'hFF));
			3: return CP_W'($urandom_range('hC0, 'hFF));
			4: begin
				case ($urandom_range(0, 5))
					0: return 21'hA0;
					1: return 21'h2028;
					2: return 21'h2029;
					3: return 21'hFFFD;
					4: return CP_W'($urandom_range(0, 'h20));
					default: return CP_W'($urandom_range('h7F, 'h9F));
				endcase
			end
			5: begin
				case ($urandom_range(0, 3))
					0: return CP_W'($urandom_range('h4E00, 'h9FFF));
					1: return CP_W'($urandom_range('h3400, 'h4DBF));
					2: return CP_W'($urandom_range('h20000, 'h2A6DF));
					default: return CP_W'($urandom_range('hF900, 'hFAFF));
				endcase
			end
			6: return CP_W'($urandom_range('h80, 'h7FF));
			7: return CP_W'($urandom_range('h800, 'hFFFF));
			8: return CP_W'($urandom_range('h10000, 'h1FFFFF));
			default: return CP_W'($urandom_range('h20, 'h7E));
		endcase
	endfunction

	// Mostly well-formed sequences; some noise, cut-off and corrupted ones
	task send_random_text(input int count);
		byte_q_t seq;
		int      sent;
		int      mode;
		logic    eot_end;
		sent = 0;
		while (sent < count) begin
			seq     = utf8_of(pick_codepoint());
			eot_end = ($urandom_range(0, 9) == 0);
			mode    = $urandom_range(0, 11);
			if (mode == 8 || mode == 9) begin
				seq     = {};
				seq.insert(seq.size(), 8'($urandom_range(0, 255)));
				eot_end = ($urandom_range(0, 3) == 0);
			end else if (mode == 10 && seq.size() > 1) begin
				seq     = seq[0:$urandom_range(0, seq.size() - 2)];
				eot_end = 1'b1;
			end else if (mode == 11 && seq.size() > 1) begin
				seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(0, 255));
			end
			foreach (seq[i]) send_text_byte(seq[i], eot_end && i == seq.size() - 1);
			sent += seq.size();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset enables: capital, dropped control, tab, standalone Latin-1, lone C1 byte
		send_text_byte(8'h41, 1'b0);
		send_text_byte(8'h00, 1'b0);
		send_text_byte(8'h09, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text_byte(8'h80, 1'b0);
		// A-grave, line separator, replacement character
		send_text_byte(8'hC3, 1'b0);
		send_text_byte(8'h80, 1'b0);
		send_text_byte(8'hE2, 1'b0);
		send_text_byte(8'h80, 1'b0);
		send_text_byte(8'hA8, 1'b0);
		send_text_byte(8'hEF, 1'b0);
		send_text_byte(8'hBF, 1'b0);
		send_text_byte(8'hBD, 1'b0);
		// Four-byte ideograph padded by spaces, then the largest codepoint
		send_text_byte(8'hF0, 1'b0);
		send_text_byte(8'hA0, 1'b0);
		send_text_byte(8'h80, 1'b0);
		send_text_byte(8'h80, 1'b0);
		send_text_byte(8'hF7, 1'b0);
		send_text_byte(8'hBF, 1'b0);
		send_text_byte(8'hBF, 1'b0);
		send_text_byte(8'hBF, 1'b0);
		// Following byte with wrong top bits
		send_text_byte(8'hC3, 1'b0);
		send_text_byte(8'h41, 1'b0);
		// Text ends mid-sequence, and again right on a lead byte
		send_text_byte(8'hE4, 1'b0);
		send_text_byte(8'hB8, 1'b1);
		send_text_byte(8'hF7, 1'b1);
		send_random_text(60);
		settle();

		// Both enables off, with a long output stall at the start
		apply_settings(1'b0, 1'b0);
		hold_req = 1'b1;
		send_random_text(65);
		settle();

		apply_settings(1'b1, 1'b0);
		send_random_text(65);
		settle();

		apply_settings(1'b0, 1'b1);
		send_random_text(65);
		settle();

		// Full rate on both sides for the last stretch
		idle_on = 1'b0;
		apply_settings(1'b1, 1'b1);
		send_random_text(65);
		settle();

		$display("Ran %0d text bytes (%0d ending a text) under %0d enable settings.",
			text_check.noted, sent_eot, settings);
		$display("Compared %0d output bytes with idle bursts and one long output stall.",
			text_check.checked);
		if (text_check.failures() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/utn_pkg.sv
hdl/utn_decode.sv
hdl/utn_emit.sv
hdl/utf8_text_normalizer.sv
sim/testbench.sv
